>>> rtl/gp0csf_pkg.sv
`timescale 1ns / 1ps

package gp0csf_pkg;

  localparam int VRAM_X_W     = 10;
  localparam int VRAM_Y_W     = 9;
  localparam int ADDR_W       = VRAM_X_W + VRAM_Y_W;
  localparam int BUFFER_WORDS = 16;

  localparam logic [31:0] TERM_MASK = 32'hF000_F000;
  localparam logic [31:0] TERM_CODE = 32'h5000_5000;

  localparam logic [7:0] OP_FILL   = 8'h02;
  localparam logic [7:0] GP1_RESET = 8'h00;
  localparam logic [7:0] GP1_CLEAR = 8'h01;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COLLECT = 2'd1,
    ST_POLY    = 2'd2,
    ST_DATA    = 2'd3
  } state_e;

  typedef enum logic [1:0] {
    KIND_FIXED  = 2'd0,
    KIND_POLY   = 2'd1,
    KIND_UPLOAD = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ROLE_NONE     = 3'd0,
    ROLE_START    = 3'd1,
    ROLE_PARAM    = 3'd2,
    ROLE_VERTEX   = 3'd3,
    ROLE_POLY_END = 3'd4,
    ROLE_PIXEL    = 3'd5
  } role_e;

  typedef struct packed {
    logic [3:0] len;
    kind_e      kind;
  } cmd_info_t;

  typedef struct packed {
    role_e             role;
    logic [7:0]        opcode;
    logic [3:0]        word_index;
    logic              command_done;
    logic              busy;
    logic              pix_valid_lo;
    logic [ADDR_W-1:0] pix_addr_lo;
    logic [15:0]       pix_lo;
    logic              pix_valid_hi;
    logic [ADDR_W-1:0] pix_addr_hi;
    logic [15:0]       pix_hi;
  } result_t;

  // words of a command, command word included, and its kind; polylines get one, uploads count header words only
  function automatic cmd_info_t cmd_info(input logic [7:0] op);
    cmd_info_t  info;
    logic [3:0] verts;
    info.kind = KIND_FIXED;
    info.len  = 4'd1;
    verts     = op[3] ? 4'd4 : 4'd3;
    if (op == OP_FILL) begin
      info.len = 4'd3;
    end else if (op <= 8'h1F) begin
      info.len = 4'd1;
    end else if (op <= 8'h3F) begin
      // polygons: gouraud adds a color per vertex, texture a uv per vertex
      if (!op[4] && !op[2]) info.len = 4'd1 + verts;
      else if (!op[4])      info.len = 4'd1 + (verts << 1);
      else if (!op[2])      info.len = verts << 1;
      else                  info.len = verts + (verts << 1);
    end else if (op <= 8'h5F) begin
      if (op[3]) info.kind = KIND_POLY;
      else       info.len  = op[4] ? 4'd4 : 4'd3;
    end else if (op <= 8'h7F) begin
      info.len = 4'd2 + {3'd0, (op[4:3] == 2'd0)} + {3'd0, op[2]};
    end else if (op <= 8'h9F) begin
      info.len = 4'd4;
    end else if (op <= 8'hBF) begin
      info.kind = KIND_UPLOAD;
      info.len  = 4'd3;
    end else if (op <= 8'hDF) begin
      info.len = 4'd3;
    end
    return info;
  endfunction

endpackage

>>> rtl/gp0csf_in_reg.sv
`timescale 1ns / 1ps

module gp0csf_in_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] word_i,
  input  logic        adv_i,
  output logic        valid_o,
  output logic        mode_o,
  output logic [31:0] word_o
);

  logic        valid_q, valid_d;
  logic        mode_q;
  logic [31:0] word_q;
  logic        load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q <= mode_i;
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign word_o  = word_q;

endmodule

>>> rtl/gp0csf_framer.sv
`timescale 1ns / 1ps

module gp0csf_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                mode_i,
  input  logic [31:0]         word_i,
  output gp0csf_pkg::result_t res_o
);

  localparam int XW = gp0csf_pkg::VRAM_X_W;
  localparam int YW = gp0csf_pkg::VRAM_Y_W;

  gp0csf_pkg::state_e state_q, state_d;
  logic [7:0]    opcode_q, opcode_d;
  logic [3:0]    needed_q, needed_d;
  logic [3:0]    taken_q, taken_d;
  logic [XW-1:0] dest_x_q, dest_x_d;
  logic [YW-1:0] dest_y_q, dest_y_d;
  logic [XW-1:0] base_x_q, base_x_d;
  logic [YW-1:0] base_y_q, base_y_d;
  logic [XW:0]   width_q, width_d;
  logic [YW:0]   height_q, height_d;
  logic [XW-1:0] column_q, column_d;
  logic [YW:0]   row_q, row_d;

  logic [7:0]     op;
  gp0csf_pkg::cmd_info_t info_new, info_cur;
  logic [3:0]     taken_inc, taken_col;
  logic [XW-1:0]  xs_m1;
  logic [YW-1:0]  ys_m1;

  // two pixel slots per data word
  logic           pv0, pv1, wrap0, wrap1;
  logic [XW:0]    col_inc0, col_inc1;
  logic [XW-1:0]  col1, col2;
  logic [YW:0]    row1, row2;
  logic [XW-1:0]  x0, x1;
  logic [YW-1:0]  y0, y1;

  always_comb begin
    pv0      = row_q < height_q;
    x0       = base_x_q + column_q;
    y0       = base_y_q + row_q[YW-1:0];
    col_inc0 = {1'b0, column_q} + 1'b1;
    wrap0    = col_inc0 >= width_q;
    col1     = column_q;
    row1     = row_q;
    if (pv0) begin
      col1 = wrap0 ? '0 : col_inc0[XW-1:0];
      row1 = wrap0 ? row_q + 1'b1 : row_q;
    end
    pv1      = row1 < height_q;
    x1       = base_x_q + col1;
    y1       = base_y_q + row1[YW-1:0];
    col_inc1 = {1'b0, col1} + 1'b1;
    wrap1    = col_inc1 >= width_q;
    col2     = col1;
    row2     = row1;
    if (pv1) begin
      col2 = wrap1 ? '0 : col_inc1[XW-1:0];
      row2 = wrap1 ? row1 + 1'b1 : row1;
    end
  end

  always_comb begin
    op        = word_i[31:24];
    info_new  = gp0csf_pkg::cmd_info(op);
    info_cur  = gp0csf_pkg::cmd_info(opcode_q);
    taken_inc = (taken_q < 4'd15) ? taken_q + 1'b1 : taken_q;
    xs_m1     = word_i[XW-1:0] - 1'b1;
    ys_m1     = word_i[16 +: YW] - 1'b1;
    taken_col = taken_q;

    state_d  = state_q;
    opcode_d = opcode_q;
    needed_d = needed_q;
    taken_d  = taken_q;
    dest_x_d = dest_x_q;
    dest_y_d = dest_y_q;
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    width_d  = width_q;
    height_d = height_q;
    column_d = column_q;
    row_d    = row_q;
    res_o    = '0;

    if (mode_i) begin
      res_o.opcode = op;
      if (op == gp0csf_pkg::GP1_RESET || op == gp0csf_pkg::GP1_CLEAR) begin
        state_d = gp0csf_pkg::ST_IDLE;
        taken_d = '0;
        if (op == gp0csf_pkg::GP1_RESET) needed_d = '0;
      end
    end else begin
      unique case (state_q)
        gp0csf_pkg::ST_DATA: begin
          res_o.role       = gp0csf_pkg::ROLE_PIXEL;
          res_o.opcode     = opcode_q;
          res_o.word_index = taken_q;
          taken_d          = taken_inc;
          if (pv0) begin
            res_o.pix_valid_lo = 1'b1;
            res_o.pix_addr_lo  = {y0, x0};
            res_o.pix_lo       = word_i[15:0];
          end
          if (pv1) begin
            res_o.pix_valid_hi = 1'b1;
            res_o.pix_addr_hi  = {y1, x1};
            res_o.pix_hi       = word_i[31:16];
          end
          column_d = col2;
          row_d    = row2;
          // the data phase ends on the word where the row count runs out; the word index is not checked
          if (row2 >= height_q) begin
            state_d            = gp0csf_pkg::ST_IDLE;
            res_o.command_done = 1'b1;
          end
        end
        gp0csf_pkg::ST_POLY: begin
          res_o.opcode     = opcode_q;
          res_o.word_index = taken_q;
          taken_d          = taken_inc;
          if ((word_i & gp0csf_pkg::TERM_MASK) == gp0csf_pkg::TERM_CODE) begin
            res_o.role = gp0csf_pkg::ROLE_POLY_END;
            state_d    = gp0csf_pkg::ST_IDLE;
          end else begin
            res_o.role = gp0csf_pkg::ROLE_VERTEX;
          end
        end
        gp0csf_pkg::ST_COLLECT: begin
          res_o.role       = gp0csf_pkg::ROLE_PARAM;
          res_o.opcode     = opcode_q;
          res_o.word_index = taken_q;
          if ({1'b0, taken_q} < 5'(gp0csf_pkg::BUFFER_WORDS) && taken_q < 4'd15) begin
            if (taken_q == 4'd1) begin
              dest_x_d = word_i[XW-1:0];
              dest_y_d = word_i[16 +: YW];
            end
            taken_col = taken_q + 1'b1;
          end
          taken_d = taken_col;
          if (taken_col >= needed_q) begin
            if (info_cur.kind == gp0csf_pkg::KIND_UPLOAD) begin
              // size of zero wraps to the full extent
              base_x_d = dest_x_q;
              base_y_d = dest_y_q;
              width_d  = {1'b0, xs_m1} + 1'b1;
              height_d = {1'b0, ys_m1} + 1'b1;
              column_d = '0;
              row_d    = '0;
              state_d  = gp0csf_pkg::ST_DATA;
            end else begin
              state_d            = gp0csf_pkg::ST_IDLE;
              res_o.command_done = 1'b1;
            end
          end
        end
        gp0csf_pkg::ST_IDLE: begin
          res_o.role   = gp0csf_pkg::ROLE_START;
          res_o.opcode = op;
          opcode_d     = op;
          taken_d      = 4'd1;
          if (info_new.kind == gp0csf_pkg::KIND_POLY) begin
            state_d = gp0csf_pkg::ST_POLY;
          end else if (info_new.len <= 4'd1) begin
            needed_d           = 4'd1;
            res_o.command_done = 1'b1;
          end else begin
            needed_d = info_new.len;
            state_d  = gp0csf_pkg::ST_COLLECT;
          end
        end
        default: begin
          state_d = gp0csf_pkg::ST_IDLE;
        end
      endcase
    end
    res_o.busy = state_d != gp0csf_pkg::ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gp0csf_pkg::ST_IDLE;
      opcode_q <= '0;
      needed_q <= '0;
      taken_q  <= '0;
      base_x_q <= '0;
      base_y_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      column_q <= '0;
      row_q    <= '0;
    end else if (adv_i) begin
      state_q  <= state_d;
      opcode_q <= opcode_d;
      needed_q <= needed_d;
      taken_q  <= taken_d;
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      width_q  <= width_d;
      height_q <= height_d;
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dest_x_q <= dest_x_d;
      dest_y_q <= dest_y_d;
    end
  end

endmodule

>>> rtl/gp0csf_out_reg.sv
`timescale 1ns / 1ps

module gp0csf_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  gp0csf_pkg::result_t res_i,
  input  logic                out_ready_i,
  output logic                valid_o,
  output gp0csf_pkg::result_t res_o
);

  logic                valid_q, valid_d;
  gp0csf_pkg::result_t res_q;

  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> rtl/gp0_command_stream_framer.sv
// path: a transaction accepted into the input register passes through the framer logic and shows
//   its result from the result register when the output side is not stalled
// throughput: one word per cycle while the output side is not stalled; input register, framer logic
//   and result register form a two-stage pipeline with ready passed back combinationally
// reset: rst_ni asynchronous active low, framer idle, counters and pipeline valids clear
`timescale 1ns / 1ps

module gp0_command_stream_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  role_o,
  output logic [7:0]  opcode_o,
  output logic [3:0]  word_index_o,
  output logic        command_done_o,
  output logic        busy_res_o,
  output logic        pixel_valid_lo_o,
  output logic [18:0] pixel_addr_lo_o,
  output logic [15:0] pixel_lo_o,
  output logic        pixel_valid_hi_o,
  output logic [18:0] pixel_addr_hi_o,
  output logic [15:0] pixel_hi_o
);

  logic                stage_valid;
  logic                stage_mode;
  logic [31:0]         stage_word;
  logic                adv;
  gp0csf_pkg::result_t res_next, res_out;

  assign adv = stage_valid && (!out_valid_o || out_ready_i);

  gp0csf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .word_i     (word_i),
    .adv_i      (adv),
    .valid_o    (stage_valid),
    .mode_o     (stage_mode),
    .word_o     (stage_word)
  );

  gp0csf_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .mode_i (stage_mode),
    .word_i (stage_word),
    .res_o  (res_next)
  );

  gp0csf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (res_next),
    .out_ready_i (out_ready_i),
    .valid_o     (out_valid_o),
    .res_o       (res_out)
  );

  assign role_o           = res_out.role;
  assign opcode_o         = res_out.opcode;
  assign word_index_o     = res_out.word_index;
  assign command_done_o   = res_out.command_done;
  assign busy_res_o       = res_out.busy;
  assign pixel_valid_lo_o = res_out.pix_valid_lo;
  assign pixel_addr_lo_o  = res_out.pix_addr_lo;
  assign pixel_lo_o       = res_out.pix_lo;
  assign pixel_valid_hi_o = res_out.pix_valid_hi;
  assign pixel_addr_hi_o  = res_out.pix_addr_hi;
  assign pixel_hi_o       = res_out.pix_hi;

endmodule

>>> rtl/gp0csf_checker.sv
`timescale 1ns / 1ps

module gp0csf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic [31:0] word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  role_o,
  input logic [7:0]  opcode_o,
  input logic [3:0]  word_index_o,
  input logic        command_done_o,
  input logic        busy_res_o,
  input logic        pixel_valid_lo_o,
  input logic [18:0] pixel_addr_lo_o,
  input logic [15:0] pixel_lo_o,
  input logic        pixel_valid_hi_o,
  input logic [18:0] pixel_addr_hi_o,
  input logic [15:0] pixel_hi_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(role_o) && $stable(opcode_o)
      && $stable(pixel_addr_lo_o) && $stable(pixel_addr_hi_o))
    else $error("result changed while stalled");

  // an unwritten half carries zeros, and the high half never goes without the low one
  a_pixel_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_valid_lo_o || (pixel_addr_lo_o == 19'd0 && pixel_lo_o == 16'd0
      && !pixel_valid_hi_o)) && (pixel_valid_hi_o || (pixel_addr_hi_o == 19'd0
      && pixel_hi_o == 16'd0)))
    else $error("pixel fields inconsistent");

  a_pixel_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_valid_lo_o |-> role_o == gp0csf_pkg::ROLE_PIXEL)
    else $error("pixel write outside pixel data");

  a_gp1_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && role_o == gp0csf_pkg::ROLE_NONE |-> !command_done_o && word_index_o == 4'd0)
    else $error("gp1 result with index or done");

  // polylines never signal completion and the terminator leaves the framer idle
  a_poly_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (role_o == gp0csf_pkg::ROLE_POLY_END || role_o == gp0csf_pkg::ROLE_VERTEX)
      |-> !command_done_o && (role_o != gp0csf_pkg::ROLE_POLY_END || !busy_res_o))
    else $error("polyline result inconsistent");

endmodule

bind gp0_command_stream_framer gp0csf_checker u_checker (.*);
